// ===== src/i2c_master_bus_sequencer_core_assert.svh =====
// assertion macros for the i2c bus sequencer
`ifndef I2C_MASTER_BUS_SEQUENCER_CORE_ASSERT_SVH
`define I2C_MASTER_BUS_SEQUENCER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define I2CMS_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define I2CMS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/i2cms_pkg.sv =====
// types and constants of the i2c bus sequencer
`default_nettype none

package i2cms_pkg;

	localparam int DELAY_W = 16;
	localparam logic [DELAY_W-1:0] BIT_DELAY_RESET = 16'd10;
	localparam int BITS_PER_BYTE = 8;

	typedef enum logic [2:0] {
		OP_START = 3'd0,
		OP_STOP  = 3'd1,
		OP_SEND  = 3'd2,
		OP_READ  = 3'd3,
		OP_WACK  = 3'd4,
		OP_ACK   = 3'd5,
		OP_NACK  = 3'd6,
		OP_PROBE = 3'd7
	} op_t;

	// bus phase being sequenced
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_START,
		PH_STOP,
		PH_SEND,
		PH_READ,
		PH_WACK,
		PH_ACK,
		PH_NACK
	} phase_t;

	// step inside a probe command
	typedef enum logic [2:0] {
		PS_STOP1,
		PS_START,
		PS_SEND,
		PS_WACK,
		PS_STOP2
	} probe_step_t;

	typedef struct packed {
		op_t        operation;
		logic [7:0] tx_byte;
		logic [7:0] rx_levels;
		logic       ack_level;
	} cmd_word_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       held;
		logic [7:0] rx_byte;
		logic       nack_seen;
		logic       last;
	} seg_word_t;

endpackage

`default_nettype wire

// ===== src/i2c_master_bus_sequencer_core.sv =====
// i2c master bus sequencer: one command word in, a run of scl/sda segment words out
//
//  channel | direction | handshake           | word
//  --------+-----------+---------------------+-------------------------------
//  cmd     | in        | cmd_valid/cmd_stall | i2cms_pkg::cmd_word_t
//  seg     | out       | seg_valid/seg_stall | i2cms_pkg::seg_word_t
//  cfg     | in        | cfg_valid/cfg_ready | 16-bit bit delay
//
// one segment word leaves the sequencer per emit; a held segment loads the
// delay counter with bit_delay and the next emit waits until it counts down
// to zero, while an unheld segment leaves the counter at zero
// a send byte command is 24 held segments
// the next command is taken in the cycle its last segment is emitted
// a waiting word in the output register holds off the next emit while seg_stall
// is high, until it is taken. reset releases both lines high and idles
`default_nettype none

`include "i2c_master_bus_sequencer_core_assert.svh"

module i2c_master_bus_sequencer_core (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cmd_valid,
	output      logic                 cmd_stall,
	input  wire i2cms_pkg::cmd_word_t cmd,
	output      logic                 seg_valid,
	input  wire logic                 seg_stall,
	output      i2cms_pkg::seg_word_t seg,
	input  wire logic                 cfg_valid,
	output      logic                 cfg_ready,
	input  wire logic [i2cms_pkg::DELAY_W-1:0] cfg_data
);

	// configuration
	logic [i2cms_pkg::DELAY_W-1:0] bit_delay_q;

	// command register and sequencer state
	i2cms_pkg::cmd_word_t     cmd_q;
	i2cms_pkg::phase_t        state_q, state_d;
	i2cms_pkg::probe_step_t   probe_q, probe_d;
	logic [1:0]               sub_q, sub_d;     // segment within a bit group
	logic [2:0]               bit_q, bit_d;     // bit group within the phase
	logic [i2cms_pkg::DELAY_W-1:0] dly_q;

	// current line drives, equal to the last segment emitted
	logic scl_q, sda_q;

	// output register
	logic                 seg_valid_q;
	i2cms_pkg::seg_word_t seg_q;

	// segment decode
	i2cms_pkg::seg_word_t seg_d;
	logic                 grp_end;
	logic                 ph_end;
	logic                 cmd_last;
	logic                 is_probe;
	logic                 last_bit;
	logic                 tx_bit;
	logic                 emit;
	logic                 cmd_acc;

	assign cfg_ready = 1'b1;

	assign is_probe = (cmd_q.operation == i2cms_pkg::OP_PROBE);
	assign last_bit = (bit_q == 3'(i2cms_pkg::BITS_PER_BYTE - 1));
	assign tx_bit   = cmd_q.tx_byte[3'd7 - bit_q];   // msb first

	// output slot free and previous segment's hold time elapsed
	assign emit = (state_q != i2cms_pkg::PH_IDLE) && (dly_q == '0)
		&& (!seg_valid_q || !seg_stall);

	// take a new command when idle or as the current one finishes
	assign cmd_stall = !((state_q == i2cms_pkg::PH_IDLE) || (emit && cmd_last));
	assign cmd_acc   = cmd_valid && !cmd_stall;

	assign seg_valid = seg_valid_q;
	assign seg       = seg_q;

	// segment levels for the current phase step
	always_comb begin
		seg_d     = '0;
		seg_d.held = 1'b1;
		grp_end   = 1'b0;
		ph_end    = 1'b0;
		case (state_q)
			i2cms_pkg::PH_START: begin
				// release both, pull sda, then pull scl
				seg_d.scl_level = (sub_q != 2'd2);
				seg_d.sda_level = (sub_q == 2'd0);
				grp_end = (sub_q == 2'd2);
				ph_end  = grp_end;
			end
			i2cms_pkg::PH_STOP: begin
				// scl high with sda low, then release sda without delay
				seg_d.scl_level = 1'b1;
				seg_d.sda_level = (sub_q == 2'd1);
				seg_d.held      = (sub_q == 2'd0);
				grp_end = (sub_q == 2'd1);
				ph_end  = grp_end;
			end
			i2cms_pkg::PH_SEND: begin
				case (sub_q)
					2'd0: begin
						seg_d.scl_level = scl_q;
						seg_d.sda_level = tx_bit;
					end
					2'd1: begin
						seg_d.scl_level = 1'b1;
						seg_d.sda_level = tx_bit;
					end
					default: begin
						// sda released after the final bit for the ack slot
						seg_d.scl_level = 1'b0;
						seg_d.sda_level = last_bit ? 1'b1 : tx_bit;
					end
				endcase
				grp_end = (sub_q == 2'd2);
				ph_end  = grp_end && last_bit;
			end
			i2cms_pkg::PH_READ: begin
				// sda keeps its drive, only scl pulses
				seg_d.scl_level = (sub_q == 2'd0);
				seg_d.sda_level = sda_q;
				grp_end = (sub_q == 2'd1);
				ph_end  = grp_end && last_bit;
			end
			i2cms_pkg::PH_WACK, i2cms_pkg::PH_NACK: begin
				seg_d.scl_level = (sub_q == 2'd0) ? scl_q : (sub_q == 2'd1);
				seg_d.sda_level = 1'b1;
				grp_end = (sub_q == 2'd2);
				ph_end  = grp_end;
			end
			i2cms_pkg::PH_ACK: begin
				// pull sda for one clock pulse, then release without delay
				seg_d.scl_level = (sub_q == 2'd0) ? scl_q : (sub_q == 2'd1);
				seg_d.sda_level = (sub_q == 2'd3);
				seg_d.held      = (sub_q != 2'd3);
				grp_end = (sub_q == 2'd3);
				ph_end  = grp_end;
			end
			default: begin
				seg_d.scl_level = scl_q;
				seg_d.sda_level = sda_q;
			end
		endcase

		cmd_last   = ph_end && (!is_probe || (probe_q == i2cms_pkg::PS_STOP2));
		seg_d.last = cmd_last;
		if (cmd_last && (cmd_q.operation == i2cms_pkg::OP_READ)) begin
			seg_d.rx_byte = cmd_q.rx_levels;
		end
		if (cmd_last && ((cmd_q.operation == i2cms_pkg::OP_WACK) || is_probe)) begin
			seg_d.nack_seen = cmd_q.ack_level;
		end
	end

	// next state of the sequencer
	always_comb begin
		state_d = state_q;
		probe_d = probe_q;
		sub_d   = sub_q;
		bit_d   = bit_q;
		if (emit) begin
			if (!grp_end) begin
				sub_d = sub_q + 2'd1;
			end else begin
				sub_d = 2'd0;
				bit_d = bit_q + 3'd1;
			end
			if (ph_end) begin
				bit_d = 3'd0;
				if (cmd_last) begin
					state_d = i2cms_pkg::PH_IDLE;
				end else begin
					// walk through the probe sequence
					case (probe_q)
						i2cms_pkg::PS_STOP1: begin
							probe_d = i2cms_pkg::PS_START;
							state_d = i2cms_pkg::PH_START;
						end
						i2cms_pkg::PS_START: begin
							probe_d = i2cms_pkg::PS_SEND;
							state_d = i2cms_pkg::PH_SEND;
						end
						i2cms_pkg::PS_SEND: begin
							probe_d = i2cms_pkg::PS_WACK;
							state_d = i2cms_pkg::PH_WACK;
						end
						default: begin
							probe_d = i2cms_pkg::PS_STOP2;
							state_d = i2cms_pkg::PH_STOP;
						end
					endcase
				end
			end
		end
		if (cmd_acc) begin
			sub_d   = 2'd0;
			bit_d   = 3'd0;
			probe_d = i2cms_pkg::PS_STOP1;
			case (cmd.operation)
				i2cms_pkg::OP_START: state_d = i2cms_pkg::PH_START;
				i2cms_pkg::OP_STOP:  state_d = i2cms_pkg::PH_STOP;
				i2cms_pkg::OP_SEND:  state_d = i2cms_pkg::PH_SEND;
				i2cms_pkg::OP_READ:  state_d = i2cms_pkg::PH_READ;
				i2cms_pkg::OP_WACK:  state_d = i2cms_pkg::PH_WACK;
				i2cms_pkg::OP_ACK:   state_d = i2cms_pkg::PH_ACK;
				i2cms_pkg::OP_NACK:  state_d = i2cms_pkg::PH_NACK;
				default:             state_d = i2cms_pkg::PH_STOP;   // probe opens with stop
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= i2cms_pkg::PH_IDLE;
			probe_q <= i2cms_pkg::PS_STOP1;
			sub_q   <= 2'd0;
			bit_q   <= 3'd0;
		end else begin
			state_q <= state_d;
			probe_q <= probe_d;
			sub_q   <= sub_d;
			bit_q   <= bit_d;
		end
	end

	// command word, payload only
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			cmd_q <= cmd;
		end
	end

	// bit delay register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_delay_q <= i2cms_pkg::BIT_DELAY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			bit_delay_q <= cfg_data;
		end
	end

	// hold timer and line drives
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dly_q <= '0;
			scl_q <= 1'b1;
			sda_q <= 1'b1;
		end else if (emit) begin
			dly_q <= seg_d.held ? bit_delay_q : '0;
			scl_q <= seg_d.scl_level;
			sda_q <= seg_d.sda_level;
		end else if (dly_q != '0) begin
			dly_q <= dly_q - 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_valid_q <= 1'b0;
		end else if (emit) begin
			seg_valid_q <= 1'b1;
		end else if (!seg_stall) begin
			seg_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			seg_q <= seg_d;
		end
	end

	// a held segment arms the timer with the configured delay
	`I2CMS_ASSERT_NEXT(a_hold_armed, clk, arst_n, emit && seg_d.held, dly_q == $past(bit_delay_q), "hold timer not loaded")
	// line drives follow the segment just emitted
	`I2CMS_ASSERT_NEXT(a_drive_track, clk, arst_n, emit, (scl_q == seg_q.scl_level) && (sda_q == seg_q.sda_level), "drive out of step with segment")
	// an unheld segment only ever releases sda
	`I2CMS_ASSERT_NOW(a_unheld_release, clk, arst_n, seg_valid_q && !seg_q.held, seg_q.sda_level, "unheld segment pulls sda")
	// status fields stay zero before the final segment
	`I2CMS_ASSERT_NOW(a_status_last, clk, arst_n, seg_valid_q && !seg_q.last, (seg_q.rx_byte == 8'd0) && !seg_q.nack_seen, "status on non-final segment")
	// no emit while the hold timer runs
	`I2CMS_ASSERT_NOW(a_no_early_emit, clk, arst_n, dly_q != '0, !emit, "segment emitted during hold")

endmodule

`default_nettype wire

// ===== dv/i2cms_segment_checker.sv =====
// segment word checker for the i2c bus sequencer: predicts every segment and compares
`timescale 1ns / 100ps

module i2cms_segment_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cmd_valid,
	input  wire logic                          cmd_stall,
	input  wire i2cms_pkg::cmd_word_t          cmd,
	input  wire logic                          seg_valid,
	input  wire logic                          seg_stall,
	input  wire i2cms_pkg::seg_word_t          seg,
	input  wire logic                          cfg_valid,
	input  wire logic                          cfg_ready,
	input  wire logic [i2cms_pkg::DELAY_W-1:0] cfg_data,
	output int                                 fault_count,
	output int                                 segs_pending,
	output int                                 cmds_seen,
	output int                                 segs_seen,
	output logic [i2cms_pkg::DELAY_W-1:0]      delay_mirror
);

	i2cms_pkg::seg_word_t segs_due[$];
	i2cms_pkg::seg_word_t due_word;
	logic      scl_q;
	logic      sda_q;

	task automatic put_seg(input logic held);
		i2cms_pkg::seg_word_t w;
		w = '0;
		w.scl_level = scl_q;
		w.sda_level = sda_q;
		w.held = held;
		segs_due.push_back(w);
	endtask

	// status fields ride on the final segment of a command
	task automatic close_cmd(input logic [7:0] rx, input logic nack);
		i2cms_pkg::seg_word_t w;
		w = segs_due.pop_back();
		w.rx_byte = rx;
		w.nack_seen = nack;
		w.last = 1'b1;
		segs_due.push_back(w);
	endtask

	task automatic start_cond();
		sda_q = 1'b1;
		scl_q = 1'b1;
		put_seg(1'b1);
		sda_q = 1'b0;
		put_seg(1'b1);
		scl_q = 1'b0;
		put_seg(1'b1);
	endtask

	task automatic stop_cond();
		sda_q = 1'b0;
		scl_q = 1'b1;
		put_seg(1'b1);
		sda_q = 1'b1;
		put_seg(1'b0);
	endtask

	task automatic shift_out(input logic [7:0] data);
		for (int i = 0; i < i2cms_pkg::BITS_PER_BYTE; i++) begin
			sda_q = data[i2cms_pkg::BITS_PER_BYTE-1-i];
			put_seg(1'b1);
			scl_q = 1'b1;
			put_seg(1'b1);
			scl_q = 1'b0;
			// release sda after the lsb so the slave can answer
			if (i == i2cms_pkg::BITS_PER_BYTE - 1)
				sda_q = 1'b1;
			put_seg(1'b1);
		end
	endtask

	// sda drive is left alone while reading
	task automatic clock_in();
		for (int i = 0; i < i2cms_pkg::BITS_PER_BYTE; i++) begin
			scl_q = 1'b1;
			put_seg(1'b1);
			scl_q = 1'b0;
			put_seg(1'b1);
		end
	endtask

	task automatic ninth_bit(input logic level);
		sda_q = level;
		put_seg(1'b1);
		scl_q = 1'b1;
		put_seg(1'b1);
		scl_q = 1'b0;
		put_seg(1'b1);
	endtask

	task automatic predict(input i2cms_pkg::cmd_word_t c);
		case (c.operation)
			i2cms_pkg::OP_START: begin
				start_cond();
				close_cmd(8'h00, 1'b0);
			end
			i2cms_pkg::OP_STOP: begin
				stop_cond();
				close_cmd(8'h00, 1'b0);
			end
			i2cms_pkg::OP_SEND: begin
				shift_out(c.tx_byte);
				close_cmd(8'h00, 1'b0);
			end
			i2cms_pkg::OP_READ: begin
				clock_in();
				close_cmd(c.rx_levels, 1'b0);
			end
			i2cms_pkg::OP_WACK: begin
				ninth_bit(1'b1);
				close_cmd(8'h00, c.ack_level);
			end
			i2cms_pkg::OP_ACK: begin
				ninth_bit(1'b0);
				sda_q = 1'b1;
				put_seg(1'b0);
				close_cmd(8'h00, 1'b0);
			end
			i2cms_pkg::OP_NACK: begin
				ninth_bit(1'b1);
				close_cmd(8'h00, 1'b0);
			end
			i2cms_pkg::OP_PROBE: begin
				stop_cond();
				start_cond();
				// no r/w bit is or-ed in, so the byte goes out as given
				shift_out(c.tx_byte);
				ninth_bit(1'b1);
				stop_cond();
				close_cmd(8'h00, c.ack_level);
			end
			default: begin
				$error("command word with unknown operation %0h", c.operation);
				fault_count++;
			end
		endcase
	endtask

	task automatic check_field(input string name, input logic [7:0] expv,
			input logic [7:0] actv);
		if (expv !== actv) begin
			$error("segment %0d field %s: expected %0h, actual %0h", segs_seen, name,
				expv, actv);
			fault_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			segs_due.delete();
			scl_q = 1'b1;
			sda_q = 1'b1;
			delay_mirror = i2cms_pkg::BIT_DELAY_RESET;
			fault_count = 0;
			segs_pending = 0;
			cmds_seen = 0;
			segs_seen = 0;
		end else begin
			// timing only, no field depends on it
			if (cfg_valid && cfg_ready)
				delay_mirror = cfg_data;
			if (cmd_valid && !cmd_stall) begin
				predict(cmd);
				cmds_seen++;
			end
			if (seg_valid && !seg_stall) begin
				if (segs_due.size() == 0) begin
					$error("segment %0d arrived with none expected: %h", segs_seen, seg);
					fault_count++;
				end else begin
					due_word = segs_due.pop_front();
					check_field("scl_level", 8'(due_word.scl_level), 8'(seg.scl_level));
					check_field("sda_level", 8'(due_word.sda_level), 8'(seg.sda_level));
					check_field("held", 8'(due_word.held), 8'(seg.held));
					check_field("rx_byte", due_word.rx_byte, seg.rx_byte);
					check_field("nack_seen", 8'(due_word.nack_seen), 8'(seg.nack_seen));
					check_field("last", 8'(due_word.last), 8'(seg.last));
				end
				segs_seen++;
			end
			segs_pending = segs_due.size();
		end
	end

endmodule

// ===== dv/tb_i2c_master_bus_sequencer_core.sv =====
// stimulus and verdict for the i2c bus sequencer, with the segment checker beside it
`timescale 1ns / 100ps

module tb_i2c_master_bus_sequencer_core;

	localparam int DELAY_W = i2cms_pkg::DELAY_W;
	// far above the slowest legal run: 34 segments per word, long stalls, long gaps
	localparam int CYCLE_LIMIT = 5_000_000;
	localparam int ITEMS_PER_PHASE = 48;

	logic                 clk;
	logic                 arst_n;
	logic                 cmd_valid;
	logic                 cmd_stall;
	i2cms_pkg::cmd_word_t cmd;
	logic                 seg_valid;
	logic                 seg_stall;
	i2cms_pkg::seg_word_t seg;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [DELAY_W-1:0]   cfg_data;

	int                   fault_count;
	int                   segs_pending;
	int                   cmds_seen;
	int                   segs_seen;
	logic [DELAY_W-1:0]   delay_mirror;

	// set during one phase to run with no gaps and no stalls
	bit                   quiet;
	int                   words_sent;
	int                   settings_used;
	int                   cycles;

	i2c_master_bus_sequencer_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.seg_valid (seg_valid),
		.seg_stall (seg_stall),
		.seg       (seg),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	i2cms_segment_checker seg_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.cmd          (cmd),
		.seg_valid    (seg_valid),
		.seg_stall    (seg_stall),
		.seg          (seg),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.fault_count  (fault_count),
		.segs_pending (segs_pending),
		.cmds_seen    (cmds_seen),
		.segs_seen    (segs_seen),
		.delay_mirror (delay_mirror)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog: a hung handshake ends the run here
	initial begin : watchdog
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// output back-pressure: free runs, short stalls, now and then a long one
	initial begin : seg_backpressure
		int  run_left;
		int  pick;
		bit  stall_now;
		run_left = 0;
		stall_now = 1'b0;
		seg_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (run_left == 0) begin
				pick = $urandom_range(0, 99);
				if (quiet || pick < 40) begin
					stall_now = 1'b0;
					run_left = $urandom_range(1, 30);
				end else if (pick < 85) begin
					stall_now = 1'b1;
					run_left = $urandom_range(1, 3);
				end else if (pick < 96) begin
					stall_now = 1'b1;
					run_left = $urandom_range(4, 12);
				end else begin
					stall_now = 1'b1;
					run_left = $urandom_range(20, 80);
				end
			end
			seg_stall <= stall_now;
			run_left--;
		end
	end

	// idle cycles before a command word: mostly none or a few, rarely many
	function automatic int cmd_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (quiet || pick < 50)
			return 0;
		else if (pick < 85)
			return $urandom_range(1, 3);
		else if (pick < 97)
			return $urandom_range(4, 15);
		else
			return $urandom_range(30, 120);
	endfunction

	// random byte and random bit for word fields
	function automatic logic [7:0] rnd8();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic rnd1();
		return 1'($urandom_range(0, 1));
	endfunction

	// called at a falling edge; returns at the falling edge after the word is taken,
	// with valid still high so a back-to-back word needs no second assignment
	task automatic send_cmd(input i2cms_pkg::op_t op, input logic [7:0] tx,
			input logic [7:0] rx, input logic ack);
		int gap;
		gap = cmd_gap();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd.operation <= op;
		cmd.tx_byte   <= tx;
		cmd.rx_levels <= rx;
		cmd.ack_level <= ack;
		cmd_valid     <= 1'b1;
		do
			@(posedge clk);
		while (cmd_stall);
		@(negedge clk);
		words_sent++;
	endtask

	// drop valid once the last word is taken, then wait for its segments
	task automatic settle();
		cmd_valid <= 1'b0;
		while (segs_pending != 0)
			@(negedge clk);
	endtask

	task automatic set_bit_delay(input logic [DELAY_W-1:0] d);
		cfg_data  <= d;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// a full addressed transfer; the address lsb picks read or write
	task automatic bus_transfer();
		logic [7:0] addr;
		int         nbytes;
		addr = rnd8();
		nbytes = $urandom_range(1, 3);
		send_cmd(i2cms_pkg::OP_START, rnd8(), rnd8(), rnd1());
		send_cmd(i2cms_pkg::OP_SEND, addr, rnd8(), rnd1());
		send_cmd(i2cms_pkg::OP_WACK, rnd8(), rnd8(), $urandom_range(0, 9) == 0);
		for (int i = 0; i < nbytes; i++) begin
			if (addr[0]) begin
				send_cmd(i2cms_pkg::OP_READ, rnd8(), rnd8(), rnd1());
				// master nacks the final byte of a read
				if (i == nbytes - 1)
					send_cmd(i2cms_pkg::OP_NACK, rnd8(), rnd8(), rnd1());
				else
					send_cmd(i2cms_pkg::OP_ACK, rnd8(), rnd8(), rnd1());
			end else begin
				send_cmd(i2cms_pkg::OP_SEND, rnd8(), rnd8(), rnd1());
				send_cmd(i2cms_pkg::OP_WACK, rnd8(), rnd8(), rnd1());
			end
		end
		send_cmd(i2cms_pkg::OP_STOP, rnd8(), rnd8(), rnd1());
	endtask

	// mostly well-formed traffic, then probes, cut-short transfers and loose words
	task automatic random_traffic(input int target);
		int pick;
		while (words_sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				bus_transfer();
			end else if (pick < 72) begin
				send_cmd(i2cms_pkg::OP_PROBE, rnd8(), rnd8(), rnd1());
			end else if (pick < 82) begin
				// transfer abandoned before the address is acknowledged
				send_cmd(i2cms_pkg::OP_START, rnd8(), rnd8(), rnd1());
				send_cmd(i2cms_pkg::OP_SEND, rnd8(), rnd8(), rnd1());
				send_cmd(i2cms_pkg::OP_STOP, rnd8(), rnd8(), rnd1());
			end else begin
				send_cmd(i2cms_pkg::op_t'($urandom_range(0, 7)), rnd8(), rnd8(), rnd1());
			end
		end
	endtask

	initial begin : stimulus
		logic [DELAY_W-1:0] phase_delay;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		quiet = 1'b0;
		words_sent = 0;
		settings_used = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed words at the reset bit delay
		// read straight out of reset, both lines released
		send_cmd(i2cms_pkg::OP_READ, 8'h00, 8'h00, 1'b0);
		// stop with no start before it
		send_cmd(i2cms_pkg::OP_STOP, 8'hFF, 8'hFF, 1'b1);
		send_cmd(i2cms_pkg::OP_START, 8'h00, 8'h00, 1'b0);
		send_cmd(i2cms_pkg::OP_SEND, 8'h00, 8'hFF, 1'b1);
		send_cmd(i2cms_pkg::OP_WACK, 8'h00, 8'h00, 1'b0);
		send_cmd(i2cms_pkg::OP_SEND, 8'hFF, 8'h00, 1'b0);
		send_cmd(i2cms_pkg::OP_WACK, 8'hFF, 8'hFF, 1'b1);
		send_cmd(i2cms_pkg::OP_READ, 8'h00, 8'hFF, 1'b0);
		send_cmd(i2cms_pkg::OP_ACK, 8'h00, 8'h00, 1'b0);
		send_cmd(i2cms_pkg::OP_READ, 8'h00, 8'h5A, 1'b1);
		send_cmd(i2cms_pkg::OP_NACK, 8'h00, 8'h00, 1'b0);
		send_cmd(i2cms_pkg::OP_STOP, 8'h00, 8'h00, 1'b0);
		// probe answered, then probe of an address with its lsb set and no answer
		send_cmd(i2cms_pkg::OP_PROBE, 8'h00, 8'h00, 1'b0);
		send_cmd(i2cms_pkg::OP_PROBE, 8'hFF, 8'hFF, 1'b1);
		// read right after start: sda stays pulled low through the read
		send_cmd(i2cms_pkg::OP_START, 8'h00, 8'h00, 1'b0);
		send_cmd(i2cms_pkg::OP_READ, 8'h00, 8'hA5, 1'b0);
		send_cmd(i2cms_pkg::OP_ACK, 8'h00, 8'h00, 1'b0);
		send_cmd(i2cms_pkg::OP_ACK, 8'h00, 8'h00, 1'b0);
		send_cmd(i2cms_pkg::OP_NACK, 8'h00, 8'h00, 1'b0);
		send_cmd(i2cms_pkg::OP_WACK, 8'h00, 8'h00, 1'b1);
		send_cmd(i2cms_pkg::OP_SEND, 8'hA5, 8'h00, 1'b0);
		// repeated start with scl low, then a double stop
		send_cmd(i2cms_pkg::OP_START, 8'h00, 8'h00, 1'b0);
		send_cmd(i2cms_pkg::OP_STOP, 8'h00, 8'h00, 1'b0);
		send_cmd(i2cms_pkg::OP_STOP, 8'h00, 8'h00, 1'b0);
		settle();

		// random phases, each under its own bit delay
		for (int phase = 0; phase < 7; phase++) begin
			case (phase)
				0: phase_delay = 16'd1;
				1: phase_delay = 16'd0;
				3: phase_delay = 16'd3;
				5: phase_delay = DELAY_W'($urandom_range(5, 40));
				6: phase_delay = i2cms_pkg::BIT_DELAY_RESET;
				default: phase_delay = DELAY_W'($urandom_range(2, 24));
			endcase
			quiet = (phase == 3);
			set_bit_delay(phase_delay);
			random_traffic(words_sent + ITEMS_PER_PHASE);
			settle();
			if (phase == 1) begin
				// longest delay: a lone stop, whose final segment is unheld so the
				// block is idle as soon as it arrives
				set_bit_delay('1);
				send_cmd(i2cms_pkg::OP_STOP, rnd8(), rnd8(), rnd1());
				settle();
			end
		end
		quiet = 1'b0;

		// let any stray segment show up before the verdict
		repeat (int'(delay_mirror) + 40) @(negedge clk);

		$display("run covered %0d command words and %0d segment words: every operation,",
			cmds_seen, segs_seen);
		$display("addressed transfers, probes, broken sequences, %0d bit delays from 0 to 65535",
			settings_used);
		if (fault_count == 0 && segs_pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== i2c_master_bus_sequencer_core.f =====
+incdir+src
src/i2cms_pkg.sv
src/i2c_master_bus_sequencer_core.sv
dv/i2cms_segment_checker.sv
dv/tb_i2c_master_bus_sequencer_core.sv
